[design/uas_command_sequencer_assert.svh]
// assertion macros shared by the sequencer rtl
`ifndef UAS_COMMAND_SEQUENCER_ASSERT_SVH
`define UAS_COMMAND_SEQUENCER_ASSERT_SVH

// invariant checked on every clock outside reset
`define UCS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// implication checked on every clock outside reset
`define UCS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/ucs_pkg.sv]
package ucs_pkg;

    localparam int CDB_BYTES         = 16;
    localparam int CMD_IU_BYTES      = 32;
    localparam int MAX_STATUS_ROUNDS = 4;
    localparam int CDB_AW            = $clog2(CDB_BYTES);
    localparam int CNT_W             = $clog2(CMD_IU_BYTES);
    localparam int PC_W              = 4;
    localparam int RND_W             = 3;

    // item kinds
    localparam logic [2:0] FN_LOAD      = 3'd0;
    localparam logic [2:0] FN_START     = 3'd1;
    localparam logic [2:0] FN_CMD_SENT  = 3'd2;
    localparam logic [2:0] FN_STATUS_IU = 3'd3;
    localparam logic [2:0] FN_DATA_DONE = 3'd4;

    // command phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_CMD    = 2'd1;
    localparam logic [1:0] PH_STATUS = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    // result actions
    localparam logic [2:0] AC_IU_BYTE  = 3'd0;
    localparam logic [2:0] AC_RD_STAT  = 3'd1;
    localparam logic [2:0] AC_DATA_IN  = 3'd2;
    localparam logic [2:0] AC_DATA_OUT = 3'd3;
    localparam logic [2:0] AC_FINISH   = 3'd4;

    // finish codes
    localparam logic [1:0] DC_GOOD  = 2'd0;
    localparam logic [1:0] DC_CHECK = 2'd1;
    localparam logic [1:0] DC_TERR  = 2'd2;

    // pipe outcomes
    localparam logic [1:0] XS_OK    = 2'd0;
    localparam logic [1:0] XS_ERROR = 2'd2;

    // iu identifiers and command iu layout
    localparam logic [7:0] IU_COMMAND     = 8'h01;
    localparam logic [7:0] IU_SENSE       = 8'h03;
    localparam logic [7:0] IU_READ_READY  = 8'h06;
    localparam logic [7:0] IU_WRITE_READY = 8'h07;
    localparam logic [CNT_W-1:0] POS_ID     = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_TAG_HI = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_TAG_LO = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_LUN    = CNT_W'(9);

    // microword emit field
    localparam logic [2:0] EM_NONE   = 3'd0;
    localparam logic [2:0] EM_IU     = 3'd1;
    localparam logic [2:0] EM_STATUS = 3'd2;
    localparam logic [2:0] EM_XFER   = 3'd3;
    localparam logic [2:0] EM_FINISH = 3'd4;

    // microword datapath op
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_INIT    = 3'd1;
    localparam logic [2:0] OP_CNT_INC = 3'd2;
    localparam logic [2:0] OP_ROUND   = 3'd3;
    localparam logic [2:0] OP_RESIDUE = 3'd4;

    // microword jump condition
    localparam logic [2:0] CD_NEVER      = 3'd0;
    localparam logic [2:0] CD_XS_NZ      = 3'd1;
    localparam logic [2:0] CD_XS_ERR     = 3'd2;
    localparam logic [2:0] CD_ID_SENSE   = 3'd3;
    localparam logic [2:0] CD_NOT_READY  = 3'd4;
    localparam logic [2:0] CD_LEN_ZERO   = 3'd5;
    localparam logic [2:0] CD_ROUNDS_MAX = 3'd6;
    localparam logic [2:0] CD_NOT_LAST   = 3'd7;

    // finish code source
    localparam logic CS_TERR  = 1'b0;
    localparam logic CS_SENSE = 1'b1;

    // microprogram addresses
    localparam logic [PC_W-1:0] UA_START     = 4'd0;
    localparam logic [PC_W-1:0] UA_IU_LOOP   = 4'd1;
    localparam logic [PC_W-1:0] UA_CMD_SENT  = 4'd2;
    localparam logic [PC_W-1:0] UA_CMD_OK    = 4'd3;
    localparam logic [PC_W-1:0] UA_STATUS    = 4'd4;
    localparam logic [PC_W-1:0] UA_ST_SENSE  = 4'd5;
    localparam logic [PC_W-1:0] UA_ST_READY  = 4'd6;
    localparam logic [PC_W-1:0] UA_ST_ROUND  = 4'd7;
    localparam logic [PC_W-1:0] UA_ST_XFER   = 4'd8;
    localparam logic [PC_W-1:0] UA_DATA_DONE = 4'd9;
    localparam logic [PC_W-1:0] UA_RESIDUE   = 4'd10;
    localparam logic [PC_W-1:0] UA_NEXT_RND  = 4'd11;
    localparam logic [PC_W-1:0] UA_RD_STAT   = 4'd12;
    localparam logic [PC_W-1:0] UA_FIN_TERR  = 4'd13;
    localparam logic [PC_W-1:0] UA_FIN_SENSE = 4'd14;

    typedef struct packed {
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
        logic [2:0]      emit;
        logic            csel;
        logic            ph_wr;
        logic [1:0]      ph_val;
        logic [2:0]      op;
        logic            fin;
    } uword_t;

    typedef struct packed {
        logic xs_nz;
        logic xs_err;
        logic id_sense;
        logic id_ready;
        logic len_zero;
        logic rounds_max;
        logic cnt_last;
        logic out_free;
    } flags_t;

    typedef struct packed {
        logic   exec;
        uword_t uw;
    } ctl_t;

    typedef struct packed {
        logic            hit;
        logic [PC_W-1:0] entry;
    } disp_t;

    function automatic uword_t mk(input logic [2:0] cond, input logic [PC_W-1:0] target,
                                  input logic [2:0] emit, input logic csel,
                                  input logic ph_wr, input logic [1:0] ph_val,
                                  input logic [2:0] op, input logic fin);
        uword_t w;
        w.cond   = cond;
        w.target = target;
        w.emit   = emit;
        w.csel   = csel;
        w.ph_wr  = ph_wr;
        w.ph_val = ph_val;
        w.op     = op;
        w.fin    = fin;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            UA_START:     w = mk(CD_NEVER, UA_START, EM_NONE, CS_TERR, 1'b1, PH_CMD,
                                 OP_INIT, 1'b0);
            UA_IU_LOOP:   w = mk(CD_NOT_LAST, UA_IU_LOOP, EM_IU, CS_TERR, 1'b0, PH_CMD,
                                 OP_CNT_INC, 1'b1);
            UA_CMD_SENT:  w = mk(CD_XS_NZ, UA_FIN_TERR, EM_NONE, CS_TERR, 1'b0, PH_CMD,
                                 OP_NONE, 1'b0);
            UA_CMD_OK:    w = mk(CD_NEVER, UA_START, EM_STATUS, CS_TERR, 1'b1, PH_STATUS,
                                 OP_NONE, 1'b1);
            UA_STATUS:    w = mk(CD_XS_ERR, UA_FIN_TERR, EM_NONE, CS_TERR, 1'b0, PH_STATUS,
                                 OP_NONE, 1'b0);
            UA_ST_SENSE:  w = mk(CD_ID_SENSE, UA_FIN_SENSE, EM_NONE, CS_TERR, 1'b0, PH_STATUS,
                                 OP_NONE, 1'b0);
            UA_ST_READY:  w = mk(CD_NOT_READY, UA_FIN_TERR, EM_NONE, CS_TERR, 1'b0, PH_STATUS,
                                 OP_NONE, 1'b0);
            UA_ST_ROUND:  w = mk(CD_LEN_ZERO, UA_NEXT_RND, EM_NONE, CS_TERR, 1'b0, PH_STATUS,
                                 OP_ROUND, 1'b0);
            UA_ST_XFER:   w = mk(CD_NEVER, UA_START, EM_XFER, CS_TERR, 1'b1, PH_DATA,
                                 OP_NONE, 1'b1);
            UA_DATA_DONE: w = mk(CD_XS_ERR, UA_FIN_TERR, EM_NONE, CS_TERR, 1'b0, PH_DATA,
                                 OP_NONE, 1'b0);
            UA_RESIDUE:   w = mk(CD_NEVER, UA_START, EM_NONE, CS_TERR, 1'b0, PH_DATA,
                                 OP_RESIDUE, 1'b0);
            UA_NEXT_RND:  w = mk(CD_ROUNDS_MAX, UA_FIN_TERR, EM_NONE, CS_TERR, 1'b0, PH_DATA,
                                 OP_NONE, 1'b0);
            UA_RD_STAT:   w = mk(CD_NEVER, UA_START, EM_STATUS, CS_TERR, 1'b1, PH_STATUS,
                                 OP_NONE, 1'b1);
            UA_FIN_TERR:  w = mk(CD_NEVER, UA_START, EM_FINISH, CS_TERR, 1'b1, PH_IDLE,
                                 OP_NONE, 1'b1);
            UA_FIN_SENSE: w = mk(CD_NEVER, UA_START, EM_FINISH, CS_SENSE, 1'b1, PH_IDLE,
                                 OP_NONE, 1'b1);
            default:      w = mk(CD_NEVER, UA_START, EM_NONE, CS_TERR, 1'b0, PH_IDLE,
                                 OP_NONE, 1'b1);
        endcase
        return w;
    endfunction

    // entry point for an item, or no hit when the item is ignored
    function automatic disp_t dispatch(input logic [2:0] func, input logic [1:0] phase);
        disp_t d;
        d.hit   = 1'b0;
        d.entry = UA_START;
        if (func == FN_START && phase == PH_IDLE) begin
            d.hit = 1'b1;
            d.entry = UA_START;
        end else if (func == FN_CMD_SENT && phase == PH_CMD) begin
            d.hit = 1'b1;
            d.entry = UA_CMD_SENT;
        end else if (func == FN_STATUS_IU && phase == PH_STATUS) begin
            d.hit = 1'b1;
            d.entry = UA_STATUS;
        end else if (func == FN_DATA_DONE && phase == PH_DATA) begin
            d.hit = 1'b1;
            d.entry = UA_DATA_DONE;
        end
        return d;
    endfunction

endpackage

[design/uas_command_sequencer.sv]
// host side transport of stream-less usb attached scsi, one command at a time
//
// input channel s_*: one item per event; s_tuser carries the item kind, s_tdata its
// fields. loads fill the 16-byte cdb store, a start builds and sends the 32-byte
// command iu, later items report pipe and status iu outcomes. items that do not
// fit the current command phase are taken and dropped without a result.
// result channel m_*: command iu bytes, status read and data transfer requests,
// and the finish item with done code and residue; m_tlast marks the final item
// of each run (byte 31 of the iu, or the single result of any other item).
// items: a load or a dropped item is taken without starting the microprogram; a start
// runs 33 steps with s_tready low (1 setup step, then one iu byte per cycle while the
// receiver keeps up); other items run 2 to 6 microprogram steps after the accepting
// cycle. the step counter walks the control rom, one step a cycle unless stalled.
// output: the first result shows on m_* in the cycle after the step that makes it.
// s_tready is low while a microprogram runs. a stalled receiver holds the
// emitting step until the output register drains; nothing is lost.
// reset: phase idle, tag, round count, length and residue cleared; the cdb
// store is not cleared and must be loaded before use.
module uas_command_sequencer #(
    parameter int MAX_ROUNDS = ucs_pkg::MAX_STATUS_ROUNDS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // cdb_index, cdb_byte, lun, cdb_len, exp_len, xfer_status, iu_id,
    // scsi_status, actual_len, zero fill
    input  logic [111:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // action, iu_byte, xfer_len, done_code, residue, zero fill
    output logic [79:0]  m_tdata,
    output logic         m_tlast
);

    // unpacked input fields
    logic [2:0]  in_func;
    logic [3:0]  in_cdb_index;
    logic [7:0]  in_cdb_byte;
    logic [7:0]  in_lun;
    logic [7:0]  in_cdb_len;
    logic [31:0] in_exp_len;
    logic [1:0]  in_xfer_status;
    logic [7:0]  in_iu_id;
    logic [7:0]  in_scsi_status;
    logic [31:0] in_actual_len;

    assign in_func        = s_tuser;
    assign in_cdb_index   = s_tdata[3:0];
    assign in_cdb_byte    = s_tdata[11:4];
    assign in_lun         = s_tdata[19:12];
    assign in_cdb_len     = s_tdata[27:20];
    assign in_exp_len     = s_tdata[59:28];
    assign in_xfer_status = s_tdata[61:60];
    assign in_iu_id       = s_tdata[69:62];
    assign in_scsi_status = s_tdata[77:70];
    assign in_actual_len  = s_tdata[109:78];

    logic                 s_acc;
    logic                 busy;
    ucs_pkg::disp_t       disp;
    ucs_pkg::flags_t      flags;
    ucs_pkg::ctl_t        ctl;
    logic                 cdb_we;
    logic [7:0]           cdb_rdata;

    // command state
    logic [1:0]                  phase_reg, phase_next;
    logic [15:0]                 tag_reg, tag_next;
    logic [ucs_pkg::RND_W-1:0]   rounds_reg, rounds_next;
    logic [31:0]                 slen_reg, slen_next;
    logic [31:0]                 sres_reg, sres_next;
    logic [ucs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // item operands held for the microprogram
    logic [1:0]  xs_reg;
    logic [7:0]  id_reg;
    logic [7:0]  sstat_reg;
    logic [31:0] alen_reg;
    logic [7:0]  lun_reg;
    logic [7:0]  clen_reg;
    logic [31:0] dlen_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [79:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic [7:0]  iu_byte;
    logic [15:0] tag_inc;

    assign s_tready = !busy;
    assign s_acc    = s_tvalid && s_tready;
    assign disp     = ucs_pkg::dispatch(in_func, phase_reg);
    assign cdb_we   = s_acc && in_func == ucs_pkg::FN_LOAD && phase_reg == ucs_pkg::PH_IDLE;

    // microprogram control: step counter, control rom and jump logic
    ucs_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_acc && disp.hit),
        .entry   (disp.entry),
        .flags   (flags),
        .busy    (busy),
        .ctl     (ctl)
    );

    // cdb store, read address follows the next byte position
    ucs_ram #(
        .WIDTH (8),
        .DEPTH (ucs_pkg::CDB_BYTES)
    ) u_cdb_ram (
        .aclk  (aclk),
        .we    (cdb_we),
        .waddr (in_cdb_index),
        .wdata (in_cdb_byte),
        .raddr (cnt_next[ucs_pkg::CDB_AW-1:0]),
        .rdata (cdb_rdata)
    );

    // condition flags for the jump logic
    assign flags.xs_nz      = xs_reg != ucs_pkg::XS_OK;
    assign flags.xs_err     = xs_reg >= ucs_pkg::XS_ERROR;
    assign flags.id_sense   = id_reg == ucs_pkg::IU_SENSE;
    assign flags.id_ready   = id_reg == ucs_pkg::IU_READ_READY ||
                              id_reg == ucs_pkg::IU_WRITE_READY;
    assign flags.len_zero   = slen_reg == 32'd0;
    assign flags.rounds_max = rounds_reg >= ucs_pkg::RND_W'(MAX_ROUNDS);
    assign flags.cnt_last   = cnt_reg == ucs_pkg::CNT_W'(ucs_pkg::CMD_IU_BYTES - 1);
    assign flags.out_free   = !m_valid_reg || m_tready;

    // tag advances and skips zero
    assign tag_inc = (tag_reg == 16'hFFFF) ? 16'd1 : tag_reg + 16'd1;

    // command iu byte at the current position; cdb region starts at byte 16
    always_comb begin
        if (cnt_reg == ucs_pkg::POS_ID) begin
            iu_byte = ucs_pkg::IU_COMMAND;
        end else if (cnt_reg == ucs_pkg::POS_TAG_HI) begin
            iu_byte = tag_reg[15:8];
        end else if (cnt_reg == ucs_pkg::POS_TAG_LO) begin
            iu_byte = tag_reg[7:0];
        end else if (cnt_reg == ucs_pkg::POS_LUN) begin
            iu_byte = lun_reg;
        end else if (cnt_reg[ucs_pkg::CNT_W-1] &&
                     clen_reg > {4'd0, cnt_reg[ucs_pkg::CDB_AW-1:0]}) begin
            iu_byte = cdb_rdata;
        end else begin
            iu_byte = 8'd0;
        end
    end

    // datapath ops driven by the current microword
    always_comb begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        rounds_next = rounds_reg;
        slen_next   = slen_reg;
        sres_next   = sres_reg;
        cnt_next    = cnt_reg;
        if (s_acc) begin
            cnt_next = '0;
        end else if (ctl.exec) begin
            if (ctl.uw.ph_wr) begin
                phase_next = ctl.uw.ph_val;
            end
            unique case (ctl.uw.op)
                ucs_pkg::OP_INIT: begin
                    tag_next    = tag_inc;
                    slen_next   = dlen_reg;
                    sres_next   = '0;
                    rounds_next = '0;
                end
                ucs_pkg::OP_CNT_INC: cnt_next = cnt_reg + ucs_pkg::CNT_W'(1);
                ucs_pkg::OP_ROUND:   rounds_next = rounds_reg + ucs_pkg::RND_W'(1);
                ucs_pkg::OP_RESIDUE: sres_next = (slen_reg > alen_reg) ?
                                                 slen_reg - alen_reg : 32'd0;
                default: ;
            endcase
        end
    end

    // result assembly into the output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (ctl.exec && ctl.uw.emit != ucs_pkg::EM_NONE) begin
            m_valid_next = 1'b1;
            m_last_next  = 1'b1;
            m_data_next  = '0;
            unique case (ctl.uw.emit)
                ucs_pkg::EM_IU: begin
                    m_data_next[2:0]  = ucs_pkg::AC_IU_BYTE;
                    m_data_next[10:3] = iu_byte;
                    m_last_next       = flags.cnt_last;
                end
                ucs_pkg::EM_STATUS: m_data_next[2:0] = ucs_pkg::AC_RD_STAT;
                ucs_pkg::EM_XFER: begin
                    m_data_next[2:0]   = (id_reg == ucs_pkg::IU_READ_READY) ?
                                         ucs_pkg::AC_DATA_IN : ucs_pkg::AC_DATA_OUT;
                    m_data_next[42:11] = slen_reg;
                end
                ucs_pkg::EM_FINISH: begin
                    m_data_next[2:0]   = ucs_pkg::AC_FINISH;
                    m_data_next[44:43] = (ctl.uw.csel == ucs_pkg::CS_TERR) ?
                                         ucs_pkg::DC_TERR :
                                         (sstat_reg == 8'd0) ? ucs_pkg::DC_GOOD :
                                                               ucs_pkg::DC_CHECK;
                    m_data_next[76:45] = sres_reg;
                end
                default: m_valid_next = 1'b0;
            endcase
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= ucs_pkg::PH_IDLE;
            tag_reg     <= '0;
            rounds_reg  <= '0;
            slen_reg    <= '0;
            sres_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            rounds_reg  <= rounds_next;
            slen_reg    <= slen_next;
            sres_reg    <= sres_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // operand capture and output payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            xs_reg    <= in_xfer_status;
            id_reg    <= in_iu_id;
            sstat_reg <= in_scsi_status;
            alen_reg  <= in_actual_len;
            lun_reg   <= in_lun;
            clen_reg  <= in_cdb_len;
            dlen_reg  <= in_exp_len;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `include "uas_command_sequencer_assert.svh"

    // data phase is only reached with a nonzero expected length
    `UCS_ASSERT_IMPLY(a_data_len, phase_reg == ucs_pkg::PH_DATA, slen_reg != 32'd0, "data phase with zero length")
    // round count never passes the limit
    `UCS_ASSERT_ALWAYS(a_rounds, rounds_reg <= ucs_pkg::RND_W'(MAX_ROUNDS), "round count past limit")
    // an active command always carries a nonzero tag
    `UCS_ASSERT_IMPLY(a_tag, phase_reg != ucs_pkg::PH_IDLE, tag_reg != 16'd0, "zero tag in active command")
    // a finish result always closes its run
    `UCS_ASSERT_IMPLY(a_fin_last, m_valid_reg && m_data_reg[2:0] == ucs_pkg::AC_FINISH, m_last_reg, "finish without last")

endmodule

[design/ucs_ram.sv]
module ucs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ucs_pkg::CDB_BYTES
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/ucs_useq.sv]
module ucs_useq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ucs_pkg::PC_W-1:0]   entry,
    input  ucs_pkg::flags_t            flags,
    output logic                       busy,
    output ucs_pkg::ctl_t              ctl
);

    logic                     busy_reg, busy_next;
    logic [ucs_pkg::PC_W-1:0] pc_reg, pc_next;
    ucs_pkg::uword_t          uw;
    logic                     exec;
    logic                     taken;

    assign uw = ucs_pkg::ucode_rom(pc_reg);

    // a step that emits waits for the output register
    assign exec = busy_reg && (uw.emit == ucs_pkg::EM_NONE || flags.out_free);

    always_comb begin
        unique case (uw.cond)
            ucs_pkg::CD_NEVER:      taken = 1'b0;
            ucs_pkg::CD_XS_NZ:      taken = flags.xs_nz;
            ucs_pkg::CD_XS_ERR:     taken = flags.xs_err;
            ucs_pkg::CD_ID_SENSE:   taken = flags.id_sense;
            ucs_pkg::CD_NOT_READY:  taken = !flags.id_ready;
            ucs_pkg::CD_LEN_ZERO:   taken = flags.len_zero;
            ucs_pkg::CD_ROUNDS_MAX: taken = flags.rounds_max;
            ucs_pkg::CD_NOT_LAST:   taken = !flags.cnt_last;
            default:                taken = 1'b0;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = entry;
        end else if (exec) begin
            if (taken) begin
                pc_next = uw.target;
            end else if (uw.fin) begin
                busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + ucs_pkg::PC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= ucs_pkg::UA_START;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy     = busy_reg;
    assign ctl.exec = exec;
    assign ctl.uw   = uw;

endmodule
